FILE: design/arbge_pkg.sv
// Shared types and constants for the adaptive Rice bit-group emitter.
// Holds the action codes, group kinds and the job record passed front to back.
// No dependencies.
`default_nettype none

package arbge_pkg;

  // unary prefix chunking and adaptation limits
  localparam int CHUNK_BITS   = 16;
  localparam int CHUNK_SH     = $clog2(CHUNK_BITS);
  localparam int MAX_K        = 15;
  localparam int PREFIX_LIMIT = 63 * CHUNK_BITS - 1;
  localparam int ESC_BASE     = 8;
  localparam int ESC_STEP     = 5;
  localparam int SYM_BITS     = 8;
  localparam int RAW_MAX      = 16;

  typedef enum logic [2:0] {
    ACT_RICE  = 3'd0,
    ACT_SRICE = 3'd1,
    ACT_ESC   = 3'd2,
    ACT_SESC  = 3'd3,
    ACT_RAW   = 3'd4,
    ACT_SYM8  = 3'd5,
    ACT_SYM16 = 3'd6
  } act_t;

  localparam logic [1:0] KIND_ADAPT = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_SYM   = 2'd2;

  typedef enum logic [2:0] {
    JOB_RICE,
    JOB_ESC,
    JOB_OVF,
    JOB_RAW,
    JOB_SYM8,
    JOB_SYM16
  } job_kind_t;

  typedef struct packed {
    job_kind_t           kind;
    logic [16:0]         u;         // folded value, raw value or symbols
    logic [3:0]          k;
    logic [3:0]          kout;
    logic [5:0]          nchunks;   // full all-ones chunks of the prefix
    logic [CHUNK_SH-1:0] rem;       // prefix ones left for the closing group
    logic [5:0]          hdr_cnt;   // escape length marker bits
    logic [5:0]          body_cnt;  // escape value bits
    logic [5:0]          raw_cnt;   // raw bits count, saturated
  } job_t;

endpackage

`default_nettype wire

FILE: design/arbge_front.sv
// Front end: registers an input item, folds the value and classifies it into a job.
// Depends on arbge_pkg.
`default_nettype none

module arbge_front import arbge_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [16:0] in_value,
  input  wire logic [3:0]  in_k,
  input  wire logic [4:0]  in_n,
  output logic             push_valid,
  input  wire logic        push_ready,
  output job_t             push_job
);

  logic        hv_r;
  act_t        act_r;
  logic [16:0] val_r;
  logic [3:0]  k_r;
  logic [4:0]  n_r;
  logic        act_ok;

  logic [16:0] u;
  logic [16:0] q;
  logic [4:0]  blen;
  logic        esc_mode;
  logic        esc_take;
  logic        ovf;
  logic [4:0]  step;
  logic [5:0]  step2;
  logic [6:0]  step3;
  logic [6:0]  step4;
  logic [2:0]  esc_i;
  logic [4:0]  k_esc;
  logic [3:0]  k_plain;

  assign in_ready   = !hv_r || push_ready;
  assign push_valid = hv_r;

  always_comb begin
    case (act_t'(in_action))
      ACT_RICE, ACT_SRICE, ACT_ESC, ACT_SESC, ACT_RAW, ACT_SYM8, ACT_SYM16: act_ok = 1'b1;
      default: act_ok = 1'b0;
    endcase
  end

  // hold one item; drop the unused action at the door
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (in_ready) begin
      hv_r <= in_valid && act_ok;
      if (in_valid) begin
        act_r <= act_t'(in_action);
        val_r <= in_value;
        k_r   <= in_k;
        n_r   <= in_n;
      end
    end
  end

  // zigzag fold: v >= 0 -> 2v, v < 0 -> ~(2v)
  always_comb begin
    if (act_r == ACT_SRICE || act_r == ACT_SESC) begin
      u = {val_r[15:0], 1'b0} ^ {17{val_r[16]}};
    end else if (act_r == ACT_RICE || act_r == ACT_ESC) begin
      u = {1'b0, val_r[15:0]};
    end else begin
      u = val_r;
    end
  end

  always_comb begin
    blen = '0;
    for (int b = 0; b < 17; b++) begin
      if (u[b]) blen = 5'(b + 1);
    end
  end

  assign q        = u >> k_r;
  assign esc_mode = (act_r == ACT_ESC) || (act_r == ACT_SESC);
  assign esc_take = esc_mode && (q >= 17'({1'b0, k_r} + 5'(ESC_BASE)));
  assign ovf      = !esc_mode && (q > 17'(PREFIX_LIMIT));

  // number of step-bit digits needed for the escape body
  assign step  = 5'({1'b0, k_r} + 5'(ESC_STEP));
  assign step2 = {step, 1'b0};
  assign step3 = 7'(step2) + 7'(step);
  assign step4 = {step, 2'b00};

  always_comb begin
    if (7'(blen) <= 7'(step))      esc_i = 3'd1;
    else if (7'(blen) <= 7'(step2)) esc_i = 3'd2;
    else if (7'(blen) <= step3)     esc_i = 3'd3;
    else                            esc_i = 3'd4;
  end

  assign k_esc = 5'({1'b0, k_r} + {1'b0, esc_i, 1'b0});

  // adaptation: q == 0 lowers k, q == 1 keeps it, else k = floor(log2 u)
  always_comb begin
    if (blen <= {1'b0, k_r}) begin
      k_plain = (k_r == 4'd0) ? 4'd0 : k_r - 4'd1;
    end else if (blen == 5'({1'b0, k_r} + 5'd1)) begin
      k_plain = k_r;
    end else if (blen - 5'd1 > 5'(MAX_K)) begin
      k_plain = 4'(MAX_K);
    end else begin
      k_plain = 4'(blen - 5'd1);
    end
  end

  always_comb begin
    push_job          = '0;
    push_job.u        = u;
    push_job.k        = k_r;
    push_job.kout     = k_r;
    push_job.nchunks  = 6'(q >> CHUNK_SH);
    push_job.rem      = q[CHUNK_SH-1:0];
    push_job.hdr_cnt  = 6'({2'b00, k_r} + 6'(ESC_BASE) + {3'b000, esc_i});
    push_job.raw_cnt  = (n_r > 5'(RAW_MAX)) ? 6'(RAW_MAX) : {1'b0, n_r};
    case (esc_i)
      3'd1:    push_job.body_cnt = {1'b0, step};
      3'd2:    push_job.body_cnt = step2;
      3'd3:    push_job.body_cnt = 6'(step3);
      default: push_job.body_cnt = 6'(step4);
    endcase
    case (act_r)
      ACT_RAW:   push_job.kind = JOB_RAW;
      ACT_SYM8:  push_job.kind = JOB_SYM8;
      ACT_SYM16: push_job.kind = JOB_SYM16;
      default: begin
        if (esc_take) begin
          push_job.kind = JOB_ESC;
          push_job.kout = (k_esc > 5'(MAX_K)) ? 4'(MAX_K) : 4'(k_esc);
        end else if (ovf) begin
          push_job.kind = JOB_OVF;
        end else begin
          push_job.kind = JOB_RICE;
          push_job.kout = k_plain;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/arbge_queue.sv
// Short job queue between the classifier and the group sequencer.
// Depends on arbge_pkg.
`default_nettype none

module arbge_queue import arbge_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic      push_ready,
  input  job_t      push_job,
  output logic      pop_valid,
  input  wire logic pop,
  output job_t      pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slots[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        slots[wp_r] <= push_job;
        wp_r        <= bump(wp_r);
      end
      if (do_pop) rp_r <= bump(rp_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/arbge_back.sv
// Back end: walks one job at a time, issuing one bit group per cycle into the
// output register unless stalled; keeps the running bit total. Uses arbge_pkg.
`default_nettype none

module arbge_back import arbge_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  output logic        q_pop,
  input  job_t        q_job,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [31:0] out_bits,
  output logic [5:0]  out_count,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_k,
  output logic [31:0] out_total,
  output logic        out_ovf,
  output logic        out_last
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_TERM,
    ST_SUFFIX,
    ST_HDR,
    ST_BODY,
    ST_SINGLE,
    ST_SYMHI,
    ST_SYMLO
  } state_t;

  state_t      state_r, state_nxt;
  job_t        job_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        ov_r;
  logic [31:0] bits_r;
  logic [5:0]  count_r;
  logic [1:0]  kind_r;
  logic [3:0]  k_r;
  logic [31:0] total_r;
  logic        ovf_r;
  logic        last_r;

  logic        adv;
  logic        emit;
  logic [31:0] g_bits;
  logic [5:0]  g_cnt;
  logic [1:0]  g_kind;
  logic        g_ovf;
  logic        g_last;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    return (n >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << n);
  endfunction

  assign adv = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    g_bits    = '0;
    g_cnt     = '0;
    g_kind    = KIND_ADAPT;
    g_ovf     = 1'b0;
    g_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cnt_nxt = q_job.nchunks;
          case (q_job.kind)
            JOB_RICE:  state_nxt = (q_job.nchunks != '0) ? ST_CHUNK : ST_TERM;
            JOB_ESC:   state_nxt = ST_HDR;
            JOB_SYM16: state_nxt = ST_SYMHI;
            default:   state_nxt = ST_SINGLE;
          endcase
        end
      end
      ST_CHUNK: begin
        emit      = 1'b1;
        g_bits    = '1;
        g_cnt     = 6'(CHUNK_BITS);
        cnt_nxt   = cnt_r - 6'd1;
        state_nxt = (cnt_r == 6'd1) ? ST_TERM : ST_CHUNK;
      end
      ST_TERM: begin
        emit      = 1'b1;
        g_bits    = low_mask(6'(job_r.rem)) << 1;
        g_cnt     = 6'(job_r.rem) + 6'd1;
        g_last    = (job_r.k == 4'd0);
        state_nxt = g_last ? ST_IDLE : ST_SUFFIX;
      end
      ST_SUFFIX: begin
        emit      = 1'b1;
        g_bits    = 32'(job_r.u);
        g_cnt     = {2'b00, job_r.k};
        g_last    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_HDR: begin
        emit      = 1'b1;
        g_bits    = 32'hFFFF_FFFE;
        g_cnt     = job_r.hdr_cnt;
        state_nxt = ST_BODY;
      end
      ST_BODY: begin
        emit      = 1'b1;
        g_bits    = 32'(job_r.u);
        g_cnt     = job_r.body_cnt;
        g_last    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SINGLE: begin
        emit      = 1'b1;
        g_last    = 1'b1;
        state_nxt = ST_IDLE;
        case (job_r.kind)
          JOB_OVF: g_ovf = 1'b1;
          JOB_RAW: begin
            g_bits = 32'(job_r.u);
            g_cnt  = job_r.raw_cnt;
            g_kind = KIND_RAW;
          end
          default: begin
            g_bits = 32'(job_r.u[7:0]);
            g_cnt  = 6'(SYM_BITS);
            g_kind = KIND_SYM;
          end
        endcase
      end
      ST_SYMHI: begin
        emit      = 1'b1;
        g_bits    = 32'(job_r.u[15:8]);
        g_cnt     = 6'(SYM_BITS);
        g_kind    = KIND_SYM;
        state_nxt = ST_SYMLO;
      end
      ST_SYMLO: begin
        emit      = 1'b1;
        g_bits    = 32'(job_r.u[7:0]);
        g_cnt     = 6'(SYM_BITS);
        g_kind    = KIND_SYM;
        g_last    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // stall: hold position while the output register is full
    if (emit && !adv) begin
      state_nxt = state_r;
      cnt_nxt   = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (q_pop) job_r <= q_job;
      if (adv) ov_r <= emit;
      if (emit && adv) begin
        bits_r  <= g_bits & low_mask(g_cnt);
        count_r <= g_cnt;
        kind_r  <= g_kind;
        k_r     <= job_r.kout;
        ovf_r   <= g_ovf;
        last_r  <= g_last;
        total_r <= total_r + 32'(g_cnt);
      end
    end
  end

  assign out_valid = ov_r;
  assign out_bits  = bits_r;
  assign out_count = count_r;
  assign out_kind  = kind_r;
  assign out_k     = k_r;
  assign out_total = total_r;
  assign out_ovf   = ovf_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

FILE: design/adaptive_rice_bit_group_emitter_core.sv
// Adaptive Rice bit-group emitter: an input word passes the front register and the job
// queue to the sequencer, which picks up each job and then issues its groups one at a time
// into the output register (sym8: one group, sym16: two, Rice: chunks, closing, suffix if k > 0).
// The front accepts a word per cycle while the job queue has room.
// Reset: synchronous, active low; clears the queue, sequencer and the bit total.
`default_nettype none

module adaptive_rice_bit_group_emitter_core import arbge_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [16:0] value, [20:17] rice_param_in, [25:21] bit_count, [31:26] zero
  input  wire logic [31:0] in_tdata,
  // [2:0] action
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] group_bits, [37:32] group_count, [41:38] rice_param_out,
  // [73:42] bits_written, [79:74] zero
  output logic [79:0]      out_tdata,
  // [1:0] group_kind, [2] overflow
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);

  // front to queue
  logic push_valid;
  logic push_ready;
  job_t push_job;

  // queue to back
  logic q_valid;
  logic q_pop;
  job_t q_job;

  logic [31:0] o_bits;
  logic [5:0]  o_count;
  logic [1:0]  o_kind;
  logic [3:0]  o_k;
  logic [31:0] o_total;
  logic        o_ovf;

  // classify: fold, bit length, prefix split, escape digit count, new k
  arbge_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_value   (in_tdata[16:0]),
    .in_k       (in_tdata[20:17]),
    .in_n       (in_tdata[25:21]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // decouple classification from group issue
  arbge_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_job)
  );

  // issue groups one per cycle, when not stalled, into the output register
  arbge_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bits  (o_bits),
    .out_count (o_count),
    .out_kind  (o_kind),
    .out_k     (o_k),
    .out_total (o_total),
    .out_ovf   (o_ovf),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, o_total, o_k, o_count, o_bits};
  assign out_tuser = {o_ovf, o_kind};

  // an overflow result is the only result of its item and carries no bits
  a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_ovf |-> out_tlast && o_count == 6'd0 && o_kind == KIND_ADAPT)
    else $error("overflow result not a lone empty group");

  // no group is ever wider than the 32-bit pattern
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_count <= 6'd32)
    else $error("group count above 32");

  // the sequencer only takes a job that the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // the running total moves only when a group is loaded into the output register
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(o_total))
    else $error("bit total changed while a group waits");

endmodule

`default_nettype wire

FILE: verif/rice_group_checker.sv
// Checker for the adaptive Rice bit-group emitter: predicts the bit groups of every
// accepted input word and compares each output word with the oldest prediction.
// Depends on arbge_pkg for action codes, group kinds and the coding limits.

module rice_group_checker import arbge_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          groups_checked,
  output int          overflows_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] bits;
    logic [5:0]  count;
    logic [1:0]  kind;
    logic [3:0]  k_next;
    logic [31:0] total;
    logic        ovf;
    logic        last;
  } group_t;

  group_t      groups_due[$];
  logic [31:0] bits_issued = '0;
  int          errors = 0;
  int          due_count = 0;
  int          checked = 0;
  int          ovf_count = 0;

  assign fail_count     = errors;
  assign pending        = due_count;
  assign groups_checked = checked;
  assign overflows_seen = ovf_count;

  function automatic logic [31:0] low_ones(int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  // Build one group and add its length to the running bit total.
  function automatic group_t issue(logic [31:0] bits, int n, logic [1:0] kind);
    group_t g;
    bits_issued = bits_issued + n;
    g.bits   = bits & low_ones(n);
    g.count  = 6'(n);
    g.kind   = kind;
    g.k_next = '0;
    g.total  = bits_issued;
    g.ovf    = 1'b0;
    g.last   = 1'b0;
    return g;
  endfunction

  task automatic predict_groups(input logic [2:0] act, input logic [16:0] val,
                                input logic [3:0] k, input logic [4:0] n);
    group_t      batch[$];
    group_t      g;
    logic [31:0] u, q, j, t;
    int          sv, step, i, kk, nsat;
    logic        escape, signed_mode;
    logic [3:0]  k_next;
    k_next      = k;
    signed_mode = (act == ACT_SRICE) || (act == ACT_SESC);
    escape      = (act == ACT_ESC) || (act == ACT_SESC);
    case (act)
      ACT_RICE, ACT_SRICE, ACT_ESC, ACT_SESC: begin
        // signed modes fold: v >= 0 -> 2v, v < 0 -> -2v-1
        if (signed_mode) begin
          sv = $signed(val);
          u  = (sv >= 0) ? 32'(2 * sv) : 32'(-2 * sv - 1);
        end else begin
          u = {16'd0, val[15:0]};
        end
        q = u >> k;
        if (escape && q >= 32'(ESC_BASE) + k) begin
          // length marker, then i chunks of (5 + k) value bits
          step = ESC_STEP + k;
          i    = 1;
          t    = u;
          while (t >= (32'd1 << step)) begin
            t = t >> step;
            i++;
          end
          batch.push_back(issue(32'hFFFF_FFFE, ESC_BASE + k + i, KIND_ADAPT));
          batch.push_back(issue(u, i * step, KIND_ADAPT));
          kk     = k + 2 * i;
          k_next = 4'((kk > MAX_K) ? MAX_K : kk);
        end else if (!escape && q > PREFIX_LIMIT) begin
          g     = issue(32'd0, 0, KIND_ADAPT);
          g.ovf = 1'b1;
          batch.push_back(g);
          ovf_count++;
        end else begin
          j = q;
          while (j >= CHUNK_BITS) begin
            batch.push_back(issue(32'hFFFF_FFFF, CHUNK_BITS, KIND_ADAPT));
            j = j - CHUNK_BITS;
          end
          batch.push_back(issue(low_ones(j) << 1, j + 1, KIND_ADAPT));
          if (k != 0) batch.push_back(issue(u, k, KIND_ADAPT));
          if (q == 0) begin
            k_next = (k != 0) ? k - 4'd1 : 4'd0;
          end else if (q > 1) begin
            kk = k;
            j  = q;
            while (j > 1) begin
              kk++;
              j = j >> 1;
            end
            k_next = 4'((kk > MAX_K) ? MAX_K : kk);
          end
        end
      end
      ACT_RAW: begin
        nsat = (n > RAW_MAX) ? RAW_MAX : n;
        batch.push_back(issue({15'd0, val}, nsat, KIND_RAW));
      end
      ACT_SYM8: begin
        batch.push_back(issue({24'd0, val[7:0]}, SYM_BITS, KIND_SYM));
      end
      ACT_SYM16: begin
        batch.push_back(issue({24'd0, val[15:8]}, SYM_BITS, KIND_SYM));
        batch.push_back(issue({24'd0, val[7:0]}, SYM_BITS, KIND_SYM));
      end
      default: ;
    endcase
    foreach (batch[idx]) begin
      g        = batch[idx];
      g.k_next = k_next;
      g.last   = (idx == batch.size() - 1);
      groups_due.push_back(g);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: group %0d %s expected 0x%0h, got 0x%0h",
               $time, checked, name, want, got);
    end
  endtask

  task automatic check_group();
    group_t want;
    if (groups_due.size() == 0) begin
      errors++;
      $display("%0t ns: group with nothing predicted, expected none, got bits 0x%0h count %0d",
               $time, out_tdata[31:0], out_tdata[37:32]);
      return;
    end
    want = groups_due.pop_front();
    checked++;
    compare_field("group_bits", want.bits, out_tdata[31:0]);
    compare_field("group_count", want.count, out_tdata[37:32]);
    compare_field("rice_param_out", want.k_next, out_tdata[41:38]);
    compare_field("bits_written", want.total, out_tdata[73:42]);
    compare_field("group_kind", want.kind, out_tuser[1:0]);
    compare_field("overflow", want.ovf, out_tuser[2]);
    compare_field("last", want.last, out_tlast);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      groups_due.delete();
      bits_issued = '0;
    end else begin
      if (in_tvalid && in_tready)
        predict_groups(in_tuser, in_tdata[16:0], in_tdata[20:17], in_tdata[25:21]);
      if (out_tvalid && out_tready) check_group();
    end
    due_count <= groups_due.size();
  end

endmodule

FILE: verif/adaptive_rice_bit_group_emitter_core_test.sv
// Top of the emitter testbench: clock, reset, input and output stream drivers.
// Instantiates adaptive_rice_bit_group_emitter_core and rice_group_checker,
// which does all prediction and comparison; depends on arbge_pkg.

module adaptive_rice_bit_group_emitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import arbge_pkg::*;

  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         RANDOM_WORDS    = 93;
  localparam logic [2:0] ACT_UNUSED      = 3'd7;

  // idle percentages per random phase: sender, receiver
  localparam int SEND_IDLE [3] = '{27, 51, 0};
  localparam int RECV_IDLE [3] = '{51, 27, 0};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [16:0] value, [20:17] rice_param_in, [25:21] bit_count
  logic [2:0]  in_tuser   = '0;   // [2:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;         // [31:0] bits, [37:32] count, [41:38] k, [73:42] total
  logic [2:0]  out_tuser;         // [1:0] group_kind, [2] overflow
  logic        out_tlast;

  int   send_idle   = 0;
  int   recv_idle   = 0;
  int   words_coded = 0;
  int   cycle_count = 0;
  int   hold_left   = 0;
  logic stall_ask   = 1'b0;
  logic stall_seen  = 1'b0;

  int fail_count, pending, groups_checked, overflows_seen;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adaptive_rice_bit_group_emitter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  rice_group_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .groups_checked(groups_checked),
    .overflows_seen(overflows_seen)
  );

  // Receiver: a toggle of stall_ask starts a long hold-off, counted here; otherwise
  // drop ready at random at the current phase's rate.
  always @(posedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      hold_left  <= HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at the %0d-cycle limit", CYCLE_LIMIT);
      $display("adaptive_rice_bit_group_emitter_core: mismatch");
      $finish;
    end
  end

  // Offer one word and hold it until accepted. Valid stays high into the next word
  // when no gap is drawn, so it is never lowered and raised in one step.
  task automatic offer_word(input logic [2:0] act, input logic [16:0] val,
                            input logic [3:0] k, input logic [4:0] n);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'd0, n, k, val};
    do @(posedge clk); while (!in_tready);
    if (act != ACT_UNUSED) words_coded++;
  endtask

  // Pause the sender until every predicted group has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Turn a folded Rice value into an in-range value field for the given action.
  // Unsigned modes sometimes present the same low 16 bits as a negative value.
  function automatic logic [16:0] rice_field(logic [2:0] act, logic [31:0] u);
    int v;
    if (act == ACT_SRICE || act == ACT_SESC) begin
      if (u > 131070) u = 131070;
      if (u[0] && u > 65535) u = u - 1;
      v = u[0] ? -int'((u + 1) >> 1) : int'(u >> 1);
    end else begin
      if (u > 65535) u = 65535;
      v = (u[15] && $urandom_range(0, 1) == 1) ? int'(u) - 65536 : int'(u);
    end
    return v[16:0];
  endfunction

  initial begin
    int          target, pick, shape, v;
    logic [2:0]  act;
    logic [3:0]  k;
    logic [4:0]  n;
    logic [16:0] val;
    logic [31:0] q;

    repeat (2) @(posedge clk);
    rst_n     <= 1'b1;
    send_idle  = SEND_IDLE[0];
    recv_idle <= RECV_IDLE[0];

    // Directed: field extremes, every action, adaptation edges, escape thresholds,
    // prefix overflow, raw count zero and saturation, the unused action code.
    offer_word(ACT_RICE,  17'h00000, 4'd0,  5'd0);   // zero at k = 0: k stays 0
    offer_word(ACT_RICE,  17'h00000, 4'd15, 5'd0);   // zero at k = 15: k drops
    offer_word(ACT_RICE,  17'h00001, 4'd0,  5'd0);   // prefix one keeps k
    offer_word(ACT_RICE,  17'h0FFFF, 4'd15, 5'd31);
    offer_word(ACT_RICE,  17'h003EF, 4'd0,  5'd0);   // longest prefix still coded
    offer_word(ACT_RICE,  17'h003F0, 4'd0,  5'd0);   // one past it: overflow
    offer_word(ACT_RICE,  17'h1FFFF, 4'd0,  5'd16);  // -1 as unsigned 0xFFFF
    offer_word(ACT_SRICE, 17'h18000, 4'd15, 5'd0);   // negative value -32768
    offer_word(ACT_SRICE, 17'h0FFFF, 4'd7,  5'd0);   // folds past the limit
    offer_word(ACT_SRICE, 17'h1FFFF, 4'd0,  5'd0);
    offer_word(ACT_ESC,   17'h0FFFF, 4'd0,  5'd0);   // escape body of four 5-bit digits
    offer_word(ACT_ESC,   17'h00007, 4'd0,  5'd0);   // just below escape
    offer_word(ACT_ESC,   17'h00008, 4'd0,  5'd0);   // escape threshold
    offer_word(ACT_ESC,   17'h0FFFF, 4'd15, 5'd0);
    offer_word(ACT_SESC,  17'h18000, 4'd3,  5'd0);
    offer_word(ACT_SESC,  17'h0FFFF, 4'd15, 5'd0);
    offer_word(ACT_SESC,  17'h00F00, 4'd1,  5'd0);
    offer_word(ACT_RAW,   17'h1ABCD, 4'd5,  5'd0);   // zero-bit raw group
    offer_word(ACT_RAW,   17'h0FFFF, 4'd9,  5'd16);
    offer_word(ACT_RAW,   17'h1FFFF, 4'd2,  5'd31);  // count saturates at 16
    offer_word(ACT_RAW,   17'h12345, 4'd6,  5'd17);
    offer_word(ACT_SYM8,  17'h000FF, 4'd4,  5'd0);
    offer_word(ACT_SYM16, 17'h18000, 4'd8,  5'd0);
    offer_word(ACT_SYM16, 17'h0FFFF, 4'd15, 5'd0);
    offer_word(ACT_UNUSED, 17'h1FFFF, 4'd15, 5'd31); // ignored by the block

    wait_drained();

    // Long output hold-off while words keep coming back to back: fill the block.
    stall_ask <= ~stall_ask;
    send_idle  = 0;
    repeat (12) begin
      v = int'($urandom_range(0, 98303)) - 32768;
      offer_word(ACT_SYM16, v[16:0], 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
    end

    // Random phases: mostly Rice words shaped by k, with some raw, symbols, fully
    // random words and the unused code mixed in.
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      send_idle  = SEND_IDLE[ph];
      recv_idle <= RECV_IDLE[ph];
      target     = words_coded + RANDOM_WORDS / 3 + (ph == 0 ? RANDOM_WORDS % 3 : 0);
      while (words_coded < target) begin
        pick = $urandom_range(0, 99);
        k    = 4'($urandom_range(0, 15));
        n    = 5'($urandom_range(0, 16));
        v    = int'($urandom_range(0, 98303)) - 32768;
        val  = v[16:0];
        if (pick < 62) begin
          act   = 3'($urandom_range(0, 3));
          shape = $urandom_range(0, 99);
          if (shape < 70)
            q = $urandom_range(0, 6);
          else if (shape < 85)
            q = $urandom_range(7, 40);
          else if (shape < 94)
            q = (act == ACT_ESC || act == ACT_SESC) ? $urandom_range(8 + k, 70 + k)
                                                    : $urandom_range(41, 300);
          else
            q = $urandom_range(0, 131071) >> k;
          val = rice_field(act, (q << k) | ($urandom & ((32'd1 << k) - 32'd1)));
        end else if (pick < 72) begin
          act = ACT_RAW;
          if ($urandom_range(0, 9) == 0) n = 5'($urandom_range(17, 31));
        end else if (pick < 82) begin
          act = ACT_SYM8;
        end else if (pick < 92) begin
          act = ACT_SYM16;
        end else if (pick < 97) begin
          act = 3'($urandom_range(0, 6));
        end else begin
          act = ACT_UNUSED;
        end
        offer_word(act, val, k, n);
      end
    end

    // Drain, then wait for any stray group to show up.
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered all actions and the unused code, overflow, escape lengths, raw");
    $display("saturation and a %0d-cycle hold-off: %0d words, %0d groups, %0d overflows.",
             HOLD_OFF_CYCLES, words_coded, groups_checked, overflows_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("adaptive_rice_bit_group_emitter_core: match");
    end else begin
      $display("adaptive_rice_bit_group_emitter_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
design/arbge_pkg.sv
design/arbge_front.sv
design/arbge_queue.sv
design/arbge_back.sv
design/adaptive_rice_bit_group_emitter_core.sv
verif/rice_group_checker.sv
verif/adaptive_rice_bit_group_emitter_core_test.sv
